### src/shared_exponent_matrix_normalize_top_macros.svh
// Assertion macros shared by the normalizer RTL.
`ifndef SHARED_EXPONENT_MATRIX_NORMALIZE_TOP_MACROS_SVH
`define SHARED_EXPONENT_MATRIX_NORMALIZE_TOP_MACROS_SVH

// Clocked check, disabled while reset is held.
`define SEM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/sem_pkg.sv
// Types and constants shared by the shared-exponent normalizer.
package sem_pkg;

  localparam int N_LANES = 6;
  localparam int ELEM_W  = 32;
  localparam int K_W     = 7;

  localparam logic [5:0]  K_MAX_LARGE = 6'd46;
  localparam logic [4:0]  K_MAX_SMALL = 5'd17;
  localparam logic [30:0] ONE_MAG     = 31'h3F80_0000;
  localparam logic [30:0] HALF_MAG    = 31'h3F00_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;
  localparam logic [7:0]  EXP_SPECIAL = 8'hFF;
  localparam logic [7:0]  EXP_ONE     = 8'd127;
  localparam logic [ELEM_W-1:0] QUIET_BIT = 32'h0040_0000;

  typedef logic [ELEM_W-1:0] elem_t;

  // Per-lane magnitude summary
  typedef struct packed {
    logic       over_one;
    logic       under_half;
    logic [5:0] need_large;  // halvings to bring below 1, capped
    logic [4:0] need_small;  // doublings to reach one half, capped
  } lane_info_t;

endpackage

### src/shared_exponent_matrix_normalize_top.sv
// Top level of the 2x3 shared-exponent (block floating point) normalizer.
//
//  channel | direction | ports                       | tdata / tuser
//  in      | slave     | in_tvalid/in_tready         | six elements / matrix_select
//  out     | master    | out_tvalid/out_tready       | k and six elements / slot_out
//
// Three register stages: lane scan, exponent merge, lane scaling.
// One matrix per cycle while the output register is not held by out_tready; out_tvalid
// rises once the matrix has passed the scan, merge and scaling registers.
// All stages advance together whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
module shared_exponent_matrix_normalize_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2
  input  logic [1:0]   in_tuser,   // matrix_select
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // shared_exp[6:0], out_r0c0 .. out_r1c2, zero pad
  output logic [1:0]   out_tuser   // slot_out
);
  import sem_pkg::*;

  `include "shared_exponent_matrix_normalize_top_macros.svh"

  logic adv;

  elem_t      in_elem [N_LANES];
  lane_info_t scan_info [N_LANES];

  logic       v1_r, v1_nxt;
  logic [1:0] sel1_r;
  elem_t      x1_r [N_LANES];
  lane_info_t info1_r [N_LANES];

  logic                  v2_r, v2_nxt;
  logic [1:0]            sel2_r;
  elem_t                 x2_r [N_LANES];
  logic signed [K_W-1:0] k2_r;
  logic signed [K_W-1:0] k_nxt;
  logic                  any_large;
  logic                  all_small;

  logic                  v3_r, v3_nxt;
  logic [1:0]            sel3_r;
  logic signed [K_W-1:0] k3_r;
  elem_t                 y3_r [N_LANES];
  elem_t                 scaled [N_LANES];

  // Global stage enable
  assign adv       = !v3_r || out_tready;
  assign in_tready = adv;

  assign v1_nxt = adv ? in_tvalid : v1_r;
  assign v2_nxt = adv ? v1_r : v2_r;
  assign v3_nxt = adv ? v2_r : v3_r;

  // Lanes: scan and scale
  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    assign in_elem[g] = in_tdata[g*ELEM_W +: ELEM_W];
    sem_lane_scan u_scan (
      .elem (in_elem[g]),
      .info (scan_info[g])
    );
    sem_lane_scale u_scale (
      .elem   (x2_r[g]),
      .k      (k2_r),
      .result (scaled[g])
    );
  end

  sem_merge u_merge (
    .info      (info1_r),
    .k         (k_nxt),
    .any_large (any_large),
    .all_small (all_small)
  );

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      sel1_r  <= in_tuser;
      x1_r    <= in_elem;
      info1_r <= scan_info;
      sel2_r  <= sel1_r;
      x2_r    <= x1_r;
      k2_r    <= k_nxt;
      sel3_r  <= sel2_r;
      k3_r    <= k2_r;
      y3_r    <= scaled;
    end
  end

  // Output packing
  assign out_tvalid = v3_r;
  assign out_tuser  = sel3_r;
  always_comb begin
    out_tdata      = '0;
    out_tdata[6:0] = k3_r;
    for (int i = 0; i < N_LANES; i++) begin
      out_tdata[K_W + i*ELEM_W +: ELEM_W] = y3_r[i];
    end
  end

  `SEM_ASSERT(a_large_halves, clk, rst_n, v1_r && any_large |-> k_nxt >= 7'sd1, "no halving")
  `SEM_ASSERT(a_mid_zero, clk, rst_n, v1_r && !any_large && !all_small |-> k_nxt == 7'sd0, "mid k")
  `SEM_ASSERT(a_k_range, clk, rst_n, out_tvalid |-> (k3_r >= -7'sd17) && (k3_r <= 7'sd46), "k range")

endmodule

### src/sem_lane_scan.sv
// One lane: classifies an element and the shift it asks for.
module sem_lane_scan (
  input  sem_pkg::elem_t      elem,
  output sem_pkg::lane_info_t info
);
  import sem_pkg::*;

  logic [7:0]  e;
  logic [30:0] mag;

  assign e   = elem[30:23];
  assign mag = elem[30:0];

  // Classification and shift demand
  always_comb begin
    info.over_one   = (mag >= ONE_MAG) && (mag <= INF_MAG);
    info.under_half = (mag < HALF_MAG);
    if (e == EXP_SPECIAL || e >= 8'd172) begin
      info.need_large = K_MAX_LARGE;
    end else if (e >= EXP_ONE) begin
      info.need_large = 6'(e - 8'd126);
    end else begin
      info.need_large = 6'd0;
    end
    if (e <= 8'd109) begin
      info.need_small = K_MAX_SMALL;
    end else if (e <= 8'd125) begin
      info.need_small = 5'(8'd126 - e);
    end else begin
      info.need_small = 5'd0;
    end
  end

endmodule

### src/sem_merge.sv
// Merge stage: combines the lane summaries into the shared exponent.
module sem_merge (
  input  sem_pkg::lane_info_t info [sem_pkg::N_LANES],
  output logic signed [sem_pkg::K_W-1:0] k,
  output logic                           any_large,
  output logic                           all_small
);
  import sem_pkg::*;

  logic [5:0] max_large;
  logic [4:0] min_small;

  always_comb begin
    any_large = 1'b0;
    all_small = 1'b1;
    max_large = 6'd0;
    min_small = K_MAX_SMALL;
    for (int i = 0; i < N_LANES; i++) begin
      any_large = any_large | info[i].over_one;
      all_small = all_small & info[i].under_half;
      if (info[i].over_one && info[i].need_large > max_large) begin
        max_large = info[i].need_large;
      end
      if (info[i].need_small < min_small) begin
        min_small = info[i].need_small;
      end
    end
    // Halve when anything is large, double when everything is small
    if (any_large) begin
      k = {1'b0, max_large};
    end else if (all_small) begin
      k = 7'd0 - {2'b00, min_small};
    end else begin
      k = '0;
    end
  end

endmodule

### src/sem_lane_scale.sv
// One lane: scales an element by 2^-k with per-step round to nearest even.
module sem_lane_scale (
  input  sem_pkg::elem_t                 elem,
  input  logic signed [sem_pkg::K_W-1:0] k,
  output sem_pkg::elem_t                 result
);
  import sem_pkg::*;

  logic        sgn;
  logic [7:0]  e;
  logic [22:0] m;
  logic [5:0]  h;
  logic [4:0]  d;
  logic [7:0]  ee;
  logic [5:0]  n;
  logic [23:0] s;
  logic [24:0] sum;
  logic [23:0] sh;
  logic [24:0] sm;
  logic        carry;
  logic [23:0] r;
  logic [4:0]  p;
  logic [40:0] t;
  logic [45:0] mw;
  logic [7:0]  ne;

  assign sgn = elem[31];
  assign e   = elem[30:23];
  assign m   = elem[22:0];
  assign h   = k[5:0];
  assign d   = 5'(7'd0 - k);

  always_comb begin
    ee    = (e == 8'd0) ? 8'd1 : e;
    n     = h - (ee[5:0] - 6'd1);
    s     = (e == 8'd0) ? {1'b0, m} : {1'b1, m};
    // Carry of s + s/2 into bit n gives the net round-up of n halvings
    sum   = {1'b0, s} + {2'b00, s[23:1]};
    sh    = s >> n;
    sm    = sum >> n;
    carry = sm[0] ^ sh[0] ^ sh[1];
    r     = sh + {23'd0, carry};
    // Leading one of a subnormal mantissa
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) p = 5'(i);
    end
    t  = {18'd0, m} << d;
    mw = {23'd0, m} << (5'd23 - p);
    ne = 8'(p) + 8'(d) - 8'd22;

    if (k == '0) begin
      result = elem;
    end else if (e == EXP_SPECIAL) begin
      result = (m != 23'd0) ? (elem | QUIET_BIT) : elem;
    end else if (k > 0) begin
      if ({2'b00, h} < ee) begin
        result = {sgn, 8'(ee - {2'b00, h}), m};
      end else begin
        result = {sgn, 7'd0, r};
      end
    end else begin
      if (e != 8'd0) begin
        result = {sgn, 8'(e + {3'b000, d}), m};
      end else if (t[40:23] == 18'd0) begin
        result = {sgn, 8'd0, t[22:0]};
      end else begin
        result = {sgn, ne, mw[22:0]};
      end
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench for the shared-exponent 2x3 matrix normalizer.
`timescale 1ns / 1ps

module tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;   // elem_r0c0, r0c1, r0c2, r1c0, r1c1, r1c2
  logic [1:0]   in_tuser;   // matrix_select
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;  // shared_exp[6:0], out_r0c0 .. out_r1c2, zero pad
  logic [1:0]   out_tuser;  // slot_out

  localparam int        N_EL     = 6;
  localparam int        K_CAP_HI = 46;
  localparam int        K_CAP_LO = -17;
  localparam bit [31:0] ONE_B    = 32'h3F80_0000;
  localparam bit [31:0] HALF_B   = 32'h3F00_0000;
  localparam bit [31:0] INF_B    = 32'h7F80_0000;
  localparam bit [31:0] QNAN_B   = 32'h0040_0000;

  typedef struct {
    bit [1:0]  slot;
    bit [6:0]  k;
    bit [31:0] el [N_EL];
  } norm_res_t;

  norm_res_t norm_q[$];
  int        n_err;
  int        n_sent;
  int        burst_left;
  int        gap_left;
  int        stall_mode;

  shared_exponent_matrix_normalize_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Halve one element, round to nearest even into subnormals
  function automatic bit [31:0] halve_elem(bit [31:0] b);
    bit [7:0]  e;
    bit [23:0] sig;
    bit [23:0] r;
    e = b[30:23];
    if (e == 8'hFF) return (b[22:0] != 0) ? (b | QNAN_B) : b;
    if (e > 1) return {b[31], e - 8'd1, b[22:0]};
    sig = {(e != 0), b[22:0]};
    r = sig >> 1;
    if (sig[0] && r[0]) r = r + 1;
    return {b[31], 31'(r)};
  endfunction

  function automatic bit [31:0] double_elem(bit [31:0] b);
    bit [7:0] e;
    e = b[30:23];
    if (e == 8'hFF) return (b[22:0] != 0) ? (b | QNAN_B) : b;
    if (e == 0) return {b[31], 7'd0, b[22:0], 1'b0};
    if (e >= 8'hFE) return {b[31], 31'b0} | INF_B;
    return {b[31], e + 8'd1, b[22:0]};
  endfunction

  function automatic bit big_mag(bit [31:0] b);
    return {1'b0, b[30:0]} >= ONE_B && {1'b0, b[30:0]} <= INF_B;
  endfunction

  function automatic bit tiny_mag(bit [31:0] b);
    return {1'b0, b[30:0]} < HALF_B;
  endfunction

  // Expected normalized matrix for one input transfer
  function automatic norm_res_t normalize_matrix(bit [1:0] sel, bit [191:0] d);
    norm_res_t r;
    int        k;
    bit        any_big;
    bit        all_tiny;
    k = 0;
    r.slot = sel;
    for (int i = 0; i < N_EL; i++) r.el[i] = d[32*i +: 32];
    any_big = 0;
    for (int i = 0; i < N_EL; i++) any_big |= big_mag(r.el[i]);
    all_tiny = 1;
    for (int i = 0; i < N_EL; i++) all_tiny &= tiny_mag(r.el[i]);
    if (any_big) begin
      while (any_big && k < K_CAP_HI) begin
        k++;
        any_big = 0;
        for (int i = 0; i < N_EL; i++) begin
          r.el[i] = halve_elem(r.el[i]);
          any_big |= big_mag(r.el[i]);
        end
      end
    end else if (all_tiny) begin
      do begin
        k--;
        all_tiny = 1;
        for (int i = 0; i < N_EL; i++) begin
          r.el[i] = double_elem(r.el[i]);
          all_tiny &= tiny_mag(r.el[i]);
        end
      end while (all_tiny && k > K_CAP_LO);
    end
    r.k = 7'(k);
    return r;
  endfunction

  // Random element biased toward interesting exponents
  function automatic bit [31:0] rand_elem();
    bit [31:0] v;
    int        pick;
    v = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: v[30:23] = 8'($urandom_range(100, 140));
      3:       v[30:23] = 8'($urandom_range(0, 3));
      4:       v[30:23] = 8'($urandom_range(150, 175));
      5:       v[30:23] = 8'($urandom_range(105, 112));
      6:       if ($urandom_range(0, 3) == 0) v[30:23] = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  // Send one matrix with bursty gaps on the input side
  task automatic send_matrix(bit [1:0] sel, bit [191:0] d);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap_left > 0) in_tvalid <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk);
        gap_left--;
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= sel;
    norm_q.push_back(normalize_matrix(sel, d));
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic fill_matrix(bit [31:0] a, bit [31:0] b, output bit [191:0] d);
    d = {b, a, b, a, b, a};
  endtask

  task automatic test_directed();
    bit [191:0] d;
    bit [31:0]  pat [18];
    pat = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F00_0000,
            32'h3EFF_FFFF, 32'h3F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF,
            32'h7F7F_FFFF, 32'h5000_0000, 32'h3000_0000, 32'h0080_0003,
            32'hFFFF_FFFF, 32'h3F80_0001};
    for (int i = 0; i < 18; i++) begin
      fill_matrix(pat[i], pat[(i * 7) % 18], d);
      send_matrix(2'(i), d);
    end
    // All NaN: neither large nor small
    send_matrix(2'd3, {6{32'h7FA0_0000}});
    send_matrix(2'd0, {6{32'h0000_0000}});
    send_matrix(2'd1, {32'h0000_0003, {5{32'h8000_0000}}});
    send_matrix(2'd2, {32'h7FC0_0000, {5{32'h0000_0001}}});
    send_matrix(2'd3, {6{32'hFFFF_FFFF}});
  endtask

  task automatic test_random(int n);
    bit [191:0] d;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < N_EL; j++) d[32*j +: 32] = rand_elem();
      if ($urandom_range(0, 7) == 0) d = {$urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom};
      send_matrix(2'($urandom_range(0, 3)), d);
    end
  endtask

  // Receiver stall pattern, changes mode now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        2:       out_tready <= ($urandom_range(0, 4) == 0);
        default: out_tready <= ~out_tready;
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    norm_res_t x;
    bit        bad;
    if (rst_n && out_tvalid && out_tready) begin
      if (norm_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: result transfer with nothing expected");
      end else begin
        x = norm_q.pop_front();
        bad = (out_tuser != x.slot) || (out_tdata[6:0] != x.k)
              || (out_tdata[199:199] != 1'b0);
        for (int i = 0; i < N_EL; i++) bad |= out_tdata[7 + 32*i +: 32] != x.el[i];
        if (bad) begin
          n_err++;
          if (n_err <= 10) begin
            $display("ERROR: slot exp %0d got %0d, k exp %0d got %0d",
                     x.slot, out_tuser, $signed(x.k), $signed(out_tdata[6:0]));
            for (int i = 0; i < N_EL; i++)
              $display("  elem %0d exp %h got %h", i, x.el[i], out_tdata[7 + 32*i +: 32]);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("shared_exponent_matrix_normalize_top verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    n_err = 0;
    n_sent = 0;
    burst_left = 0;
    gap_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1600);
    in_tvalid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_err == 0 && norm_q.size() == 0) begin
      $display("shared_exponent_matrix_normalize_top verification clean");
    end else begin
      $display("shared_exponent_matrix_normalize_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/sem_pkg.sv
src/sem_lane_scan.sv
src/sem_merge.sv
src/sem_lane_scale.sv
src/shared_exponent_matrix_normalize_top.sv
tb/sv/tb.sv
